FILE: hw/rtl/ltok_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ltok_pkg : shared types and constants of the line tokenizer
// character codes, scanner mode and number phase codes, result word layout
// ----------------------------------------------------------------------------
package ltok_pkg;

  // default widths of the line and column counters
  localparam int COLUMN_BITS_DEF = 16;
  localparam int ROW_BITS_DEF    = 32;

  // configuration port
  localparam int CFG_IDX_BITS = 8;
  localparam logic [CFG_IDX_BITS-1:0] REG_CMT_FIRST  = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] REG_CMT_SECOND = CFG_IDX_BITS'(1);
  localparam logic [7:0] CMT_FIRST_RST  = 8'd47;
  localparam logic [7:0] CMT_SECOND_RST = 8'd47;

  // character codes
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // int64 range limits for the decimal accumulate
  localparam logic [63:0] INT_LIMIT   = 64'h8000_0000_0000_0000;
  localparam logic [63:0] LIMIT_DIV10 = 64'd922337203685477580;

  // saturation limits of the result fields
  localparam logic [63:0] ROW_OUT_MAX = 64'h0000_0000_FFFF_FFFF;
  localparam logic [31:0] COL_OUT_MAX = 32'h0000_FFFF;
  localparam logic [15:0] LEN_MAX     = 16'hFFFF;

  // input item kinds
  localparam logic IK_TEXT = 1'b0;
  localparam logic IK_END  = 1'b1;

  typedef enum logic [3:0] {
    MODE_BETWEEN = 4'b0001,
    MODE_WORD    = 4'b0010,
    MODE_STRING  = 4'b0100,
    MODE_COMMENT = 4'b1000
  } mode_t;

  typedef enum logic [3:0] {
    PH_LEAD   = 4'b0001,
    PH_SIGN   = 4'b0010,
    PH_DIGITS = 4'b0100,
    PH_FAIL   = 4'b1000
  } phase_t;

  typedef enum logic [2:0] {
    RK_TEXT    = 3'd0,
    RK_WORD    = 3'd1,
    RK_INT     = 3'd2,
    RK_STRING  = 3'd3,
    RK_UNTERM  = 3'd4
  } rkind_t;

  typedef struct packed {
    rkind_t      kind;
    logic [7:0]  text;
    logic [31:0] row;
    logic [15:0] column;
    logic [15:0] length;
    logic [63:0] value;
  } res_t;

endpackage
`default_nettype wire

FILE: hw/rtl/line_tokenizer_stream.sv
`default_nettype none
// ----------------------------------------------------------------------------
// line_tokenizer_stream : byte stream line and token scanner
// splits text into words, integers and strings with row and column tracking
// ----------------------------------------------------------------------------
// flow: an accepted byte is scanned in the next cycle from the input register; its
//   result words are written into the result queue and reach the result port at its head
// throughput: one byte per cycle while the result queue has room; the queue drains one
//   word per cycle while result_stall is low, so a two-word byte is drained word by word
// reset: synchronous rst clears the scanner (row 1, column 0, between tokens),
//   empties the result queue and sets both comment marker bytes to 47
module line_tokenizer_stream
  import ltok_pkg::*;
#(
  parameter int COLUMN_BITS = COLUMN_BITS_DEF,
  parameter int ROW_BITS    = ROW_BITS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  // byte channel
  input  wire logic                    item_valid,
  output logic                         item_stall,
  input  wire logic                    kind,
  input  wire logic [7:0]              byte_req,
  // configuration channel
  input  wire logic                    cfg_valid,
  output logic                         cfg_ready,
  input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [7:0]              cfg_data,
  // result channel
  output logic                         result_valid,
  input  wire logic                    result_stall,
  output logic [2:0]                   result_kind,
  output logic [7:0]                   text_byte,
  output logic [31:0]                  row,
  output logic [15:0]                  column,
  output logic [15:0]                  length,
  output logic signed [63:0]           int_value
);

  // result queue: deep enough for two words in flight plus two being drained
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_BITS   = $clog2(FIFO_DEPTH);
  localparam int CNT_BITS   = $clog2(FIFO_DEPTH + 1);

  // running scanner state
  typedef struct packed {
    mode_t                  mode;
    logic                   held_cmt;   // first comment marker byte waiting
    logic [7:0]             held_val;
    logic                   held_cr;    // carriage return waiting for newline
    logic [ROW_BITS-1:0]    line;
    logic [COLUMN_BITS-1:0] col;
    logic [COLUMN_BITS-1:0] start;
    logic [15:0]            tlen;
    logic [63:0]            mag;
    phase_t                 phase;
    logic                   neg;
    logic                   rng;        // value left the int64 range
  } st_t;

  // scanner state plus the result words one byte produces
  typedef struct packed {
    st_t        s;
    res_t       r0;
    res_t       r1;
    logic [1:0] n;
  } work_t;

  // --------------------------------------------------------------------------
  // scanner functions, one per action of the byte loop
  // --------------------------------------------------------------------------
  function automatic st_t clear_state();
    st_t s;
    s          = '0;
    s.mode     = MODE_BETWEEN;
    s.line     = ROW_BITS'(1);
    s.phase    = PH_LEAD;
    return s;
  endfunction

  // emit a result word, row and column saturate at the field widths
  function automatic work_t put(work_t w, rkind_t k, logic [7:0] b, logic [15:0] len,
                                logic [63:0] val);
    res_t        r;
    logic [63:0] rw;
    logic [31:0] cw;
    rw       = 64'(w.s.line);
    cw       = 32'(w.s.start);
    r.kind   = k;
    r.text   = b;
    r.row    = (rw > ROW_OUT_MAX) ? ROW_OUT_MAX[31:0] : rw[31:0];
    r.column = (cw > COL_OUT_MAX) ? COL_OUT_MAX[15:0] : cw[15:0];
    r.length = len;
    r.value  = val;
    case (w.n)
      2'd0: begin
        w.r0 = r;
        w.n  = 2'd1;
      end
      2'd1: begin
        w.r1 = r;
        w.n  = 2'd2;
      end
      default: ;
    endcase
    return w;
  endfunction

  function automatic work_t count_len(work_t w);
    if (w.s.tlen != LEN_MAX) begin
      w.s.tlen = w.s.tlen + 16'd1;
    end
    return w;
  endfunction

  // decimal recognizer: leading tab-class blanks, optional sign, digits
  function automatic work_t num_feed(work_t w, logic [7:0] b);
    logic digit;
    logic lead_ws;
    logic sign;
    digit   = (b >= CH_ZERO) && (b <= CH_NINE);
    lead_ws = (b == CH_TAB) || (b == CH_VT) || (b == CH_FF) || (b == CH_CR);
    sign    = (b == CH_PLUS) || (b == CH_MINUS);
    if (w.s.phase == PH_LEAD && sign) begin
      w.s.neg   = (b == CH_MINUS);
      w.s.phase = PH_SIGN;
    end else if (!(w.s.phase == PH_LEAD && lead_ws) && w.s.phase != PH_FAIL) begin
      if (!digit) begin
        w.s.phase = PH_FAIL;
      end else begin
        w.s.phase = PH_DIGITS;
        if (!w.s.rng) begin
          // times ten as two shifts and an add
          if (w.s.mag > LIMIT_DIV10 || (w.s.mag == LIMIT_DIV10 && b[3:0] == 4'd9)) begin
            w.s.rng = 1'b1;
          end else begin
            w.s.mag = (w.s.mag << 3) + (w.s.mag << 1) + 64'(b[3:0]);
          end
        end
      end
    end
    return w;
  endfunction

  function automatic work_t word_add(work_t w, logic [7:0] b);
    w = count_len(w);
    w = num_feed(w, b);
    w = put(w, RK_TEXT, b, 16'd0, 64'd0);
    return w;
  endfunction

  function automatic work_t start_token(work_t w, logic [7:0] b,
                                        logic [COLUMN_BITS-1:0] c);
    w.s.start = c;
    w.s.tlen  = 16'd0;
    if (b == CH_QUOTE) begin
      w.s.mode = MODE_STRING;
    end else begin
      w.s.mode  = MODE_WORD;
      w.s.mag   = 64'd0;
      w.s.phase = PH_LEAD;
      w.s.neg   = 1'b0;
      w.s.rng   = 1'b0;
      w = word_add(w, b);
    end
    return w;
  endfunction

  // a held marker byte that turned out not to open a comment starts a token
  function automatic work_t flush_held(work_t w);
    if (w.s.held_cmt) begin
      w.s.held_cmt = 1'b0;
      w = start_token(w, w.s.held_val, w.s.start);
    end
    return w;
  endfunction

  function automatic work_t end_word(work_t w);
    logic ok;
    ok = (w.s.phase == PH_DIGITS) && !w.s.rng && (w.s.neg || (w.s.mag < INT_LIMIT));
    if (ok) begin
      w = put(w, RK_INT, 8'd0, w.s.tlen, w.s.neg ? (64'd0 - w.s.mag) : w.s.mag);
    end else begin
      w = put(w, RK_WORD, 8'd0, w.s.tlen, 64'd0);
    end
    w.s.mode = MODE_BETWEEN;
    return w;
  endfunction

  function automatic work_t close_open(work_t w);
    w = flush_held(w);
    case (w.s.mode)
      MODE_WORD:   w = end_word(w);
      MODE_STRING: w = put(w, RK_UNTERM, 8'd0, w.s.tlen, 64'd0);
      default: ;
    endcase
    w.s.mode = MODE_BETWEEN;
    return w;
  endfunction

  // one byte of line text (carriage returns already resolved)
  function automatic work_t proc(work_t w, logic [7:0] b, logic [7:0] first,
                                 logic [7:0] second);
    logic [COLUMN_BITS-1:0] c;
    logic                   done;
    c    = w.s.col;
    done = 1'b0;
    if (b == CH_LF) begin
      w = close_open(w);
      w.s.col = '0;
      if (w.s.line != {ROW_BITS{1'b1}}) begin
        w.s.line = w.s.line + ROW_BITS'(1);
      end
    end else begin
      if (w.s.col != {COLUMN_BITS{1'b1}}) begin
        w.s.col = w.s.col + COLUMN_BITS'(1);
      end
      if (w.s.held_cmt) begin
        if (b == second) begin
          w.s.held_cmt = 1'b0;
          w.s.mode     = MODE_COMMENT;
          done         = 1'b1;
        end else begin
          w = flush_held(w);
        end
      end
      if (!done) begin
        case (w.s.mode)
          MODE_BETWEEN: begin
            if (b == first && b != CH_SPACE) begin
              w.s.held_cmt = 1'b1;
              w.s.held_val = b;
              w.s.start    = c;
            end else if (b != CH_SPACE) begin
              w = start_token(w, b, c);
            end
          end
          MODE_WORD: begin
            if (b == CH_SPACE) begin
              w = end_word(w);
            end else begin
              w = word_add(w, b);
            end
          end
          MODE_STRING: begin
            if (b == CH_QUOTE) begin
              w = put(w, RK_STRING, 8'd0, w.s.tlen, 64'd0);
              w.s.mode = MODE_BETWEEN;
            end else begin
              w = count_len(w);
              w = put(w, RK_TEXT, b, 16'd0, 64'd0);
            end
          end
          default: ;
        endcase
      end
    end
    return w;
  endfunction

  function automatic work_t cr_arrives(work_t w, logic [7:0] second);
    if (w.s.held_cmt && second != CH_CR) begin
      w = flush_held(w);
    end
    w.s.held_cr = 1'b1;
    return w;
  endfunction

  // whole step for one input item
  function automatic work_t step(work_t w, logic k, logic [7:0] b, logic [7:0] first,
                                 logic [7:0] second);
    logic cr_plain;
    // a held carriage return not followed by a newline is an ordinary byte
    cr_plain = w.s.held_cr && (k == IK_END || b != CH_LF);
    w.s.held_cr = 1'b0;
    if (cr_plain) begin
      w = proc(w, CH_CR, first, second);
    end
    if (k == IK_END) begin
      w = close_open(w);
      w.s = clear_state();
    end else if (b == CH_CR) begin
      w = cr_arrives(w, second);
    end else begin
      w = proc(w, b, first, second);
    end
    return w;
  endfunction

  // --------------------------------------------------------------------------
  // configuration registers, always ready
  // --------------------------------------------------------------------------
  logic [7:0] cmt_first;
  logic [7:0] cmt_second;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmt_first  <= CMT_FIRST_RST;
      cmt_second <= CMT_SECOND_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_CMT_FIRST) begin
        cmt_first <= cfg_data;
      end
      if (cfg_index == REG_CMT_SECOND) begin
        cmt_second <= cfg_data;
      end
    end
  end

  // --------------------------------------------------------------------------
  // input register
  // --------------------------------------------------------------------------
  logic       stg_valid;
  logic       stg_kind;
  logic [7:0] stg_byte;
  logic       accept;

  assign accept = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else begin
      stg_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stg_kind <= kind;
      stg_byte <= byte_req;
    end
  end

  // --------------------------------------------------------------------------
  // scanner: state register and the single pass over the staged byte
  // --------------------------------------------------------------------------
  st_t        st;
  st_t        st_next;
  work_t      work_in;
  work_t      work;
  logic [1:0] n_push;

  always_comb begin
    work_in   = '0;
    work_in.s = st;
    work      = step(work_in, stg_kind, stg_byte, cmt_first, cmt_second);
    st_next   = stg_valid ? work.s : st;
    n_push    = stg_valid ? work.n : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= clear_state();
    end else begin
      st <= st_next;
    end
  end

  // --------------------------------------------------------------------------
  // result queue, up to two words written per cycle, one read
  // --------------------------------------------------------------------------
  res_t                fifo [FIFO_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] count;
  logic [CNT_BITS-1:0] count_next;
  logic                pop;
  logic [CNT_BITS:0]   level_next;

  assign pop        = result_valid && !result_stall;
  assign count_next = count + CNT_BITS'(n_push) - CNT_BITS'(pop);

  // a new byte needs room for two words once the staged byte has landed
  assign level_next = (CNT_BITS+1)'(count) + (CNT_BITS+1)'(n_push) - (CNT_BITS+1)'(pop);
  assign item_stall = level_next > (CNT_BITS+1)'(FIFO_DEPTH - 2);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_BITS'(n_push);
      rd_ptr <= rd_ptr + PTR_BITS'(pop);
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      fifo[wr_ptr] <= work.r0;
    end
    if (n_push == 2'd2) begin
      fifo[wr_ptr + PTR_BITS'(1)] <= work.r1;
    end
  end

  // head of queue drives the result port
  assign result_valid = (count != '0);
  assign result_kind  = fifo[rd_ptr].kind;
  assign text_byte    = fifo[rd_ptr].text;
  assign row          = fifo[rd_ptr].row;
  assign column       = fifo[rd_ptr].column;
  assign length       = fifo[rd_ptr].length;
  assign int_value    = fifo[rd_ptr].value;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  // queue never overfills
  a_fifo_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_BITS'(FIFO_DEPTH))
    else $error("result queue overfilled");

  // a staged byte always finds room for its words
  a_room_for_stage: assert property (@(posedge clk) disable iff (rst)
    stg_valid |-> ((CNT_BITS+1)'(count) + (CNT_BITS+1)'(n_push) - (CNT_BITS+1)'(pop))
                  <= (CNT_BITS+1)'(FIFO_DEPTH))
    else $error("staged byte overruns result queue");

  // queue level moves only with a push or a pop
  a_level_hold: assert property (@(posedge clk) disable iff (rst)
    (!stg_valid && !pop) |=> $stable(count))
    else $error("queue level changed with no traffic");

  // line counter is one-based and never wraps to zero
  a_line_nonzero: assert property (@(posedge clk) disable iff (rst)
    st.line != '0)
    else $error("line counter reached zero");

  // only integer ends carry a value
  a_value_kind: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_kind != RK_INT) |-> (int_value == 64'sd0))
    else $error("value on a non-integer result");

endmodule
`default_nettype wire
